// ===== hw/rtl/dcl2_pkg.sv =====
`timescale 1ns / 1ps
package dcl2_pkg;

  typedef struct packed {
    logic signed [23:0] head_in1;
    logic signed [23:0] head_in0;
    logic signed [23:0] cond_sample;
    logic signed [23:0] in_ch1;
    logic signed [23:0] in_ch0;
  } dcl2_in_t;

  typedef struct packed {
    logic signed [23:0] head_out1;
    logic signed [23:0] head_out0;
    logic signed [23:0] out_ch1;
    logic signed [23:0] out_ch0;
  } dcl2_out_t;

  localparam logic [2:0] RegTap0 = 3'd0;
  localparam logic [2:0] RegTap1 = 3'd1;
  localparam logic [2:0] RegTap2 = 3'd2;
  localparam logic [2:0] RegMix  = 3'd3;
  localparam logic [2:0] RegBias = 3'd4;
  localparam logic [2:0] RegObias = 3'd5;
  localparam logic [2:0] RegDil  = 3'd6;

  localparam logic signed [47:0] ClampQ28 = 48'sd805306368;
  localparam logic signed [23:0] Sat24Max = 24'sd8388607;
  localparam logic signed [23:0] Sat24Min = -24'sd8388608;
  localparam logic [23:0] TanhK27 = 24'd1769472;

  // Q.28 to Q8.16, round half up, saturated to 24 bits
  function automatic logic signed [23:0] rnd_sat(input logic signed [47:0] v);
    logic signed [47:0] r;
    begin
      r = (v + 48'sd2048) >>> 12;
      if (r > 48'sd8388607) rnd_sat = Sat24Max;
      else if (r < -48'sd8388608) rnd_sat = Sat24Min;
      else rnd_sat = r[23:0];
    end
  endfunction

  function automatic logic signed [23:0] sat25(input logic signed [24:0] v);
    begin
      if (v > 25'sd8388607) sat25 = Sat24Max;
      else if (v < -25'sd8388608) sat25 = Sat24Min;
      else sat25 = v[23:0];
    end
  endfunction

endpackage

// ===== hw/rtl/dcl2_ram.sv =====
`timescale 1ns / 1ps
module dcl2_ram #(
  parameter int Width = 48,
  parameter int Depth = 1025
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    rdata_o <= mem_q[raddr_i];
  end
endmodule

// ===== hw/rtl/dcl2_lane.sv =====
`timescale 1ns / 1ps
// One output channel: accumulate six tap products, bias and cond product
// one multiply a cycle, then clamp and form the Pade numerator and denominator,
// then divide one quotient bit a cycle.
module dcl2_lane (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic               step_i,
  input  logic signed [23:0] a_i,
  input  logic signed [15:0] w_i,
  input  logic signed [15:0] bias_i,
  output logic               done_o,
  output logic signed [23:0] act_o
);
  import dcl2_pkg::*;

  localparam logic [2:0] StIdle = 3'd0;
  localparam logic [2:0] StAcc  = 3'd1;
  localparam logic [2:0] StSq   = 3'd2;
  localparam logic [2:0] StNum  = 3'd3;
  localparam logic [2:0] StDiv  = 3'd4;
  localparam logic [2:0] StDone = 3'd5;

  logic [2:0] st_q, st_d;
  logic signed [47:0] acc_q, acc_d;
  logic signed [23:0] x_q, x_d;
  logic [23:0] x2_q, x2_d;
  logic [47:0] mag_q, mag_d;
  logic [28:0] den_q, den_d;
  logic neg_q, neg_d;
  logic [5:0] cnt_q, cnt_d;
  logic [29:0] rem_q, rem_d;
  logic [47:0] quo_q, quo_d;
  logic signed [47:0] prod, t, xr, sq;
  logic [23:0] xa;
  logic [29:0] trial;
  logic [48:0] numer_r;

  assign prod = 48'(a_i * w_i);
  assign xa = x_q[23] ? 24'(-x_q) : x_q;

  always_comb begin
    st_d = st_q; acc_d = acc_q; x_d = x_q; x2_d = x2_q; mag_d = mag_q;
    den_d = den_q; neg_d = neg_q; cnt_d = cnt_q; rem_d = rem_q; quo_d = quo_q;
    t = acc_q;
    if (t > ClampQ28) t = ClampQ28;
    if (t < -ClampQ28) t = -ClampQ28;
    xr = (t + 48'sd2048) >>> 12;
    sq = 48'(x_q * x_q);
    numer_r = 49'(mag_q) + 49'(den_q >> 1);
    trial = {rem_q[28:0], numer_r[48 - cnt_q]};
    unique case (st_q)
      StIdle: if (start_i) begin
        st_d = StAcc; acc_d = 48'(bias_i) <<< 16;
      end
      StAcc: if (step_i) acc_d = acc_q + prod;
        else begin
          st_d = StSq; x_d = xr[23:0];
        end
      StSq: begin
        x2_d = 24'((sq + 48'sd32768) >>> 16);
        st_d = StNum;
      end
      StNum: begin
        mag_d = 48'(xa) * 48'(TanhK27 + x2_q);
        den_d = 29'(TanhK27) + 29'(x2_q) * 29'd9;
        neg_d = x_q[23];
        cnt_d = 6'd0; rem_d = '0; quo_d = '0;
        st_d = StDiv;
      end
      StDiv: begin
        if (trial >= 30'(den_q)) begin
          rem_d = trial - 30'(den_q); quo_d = {quo_q[46:0], 1'b1};
        end else begin
          rem_d = trial; quo_d = {quo_q[46:0], 1'b0};
        end
        cnt_d = cnt_q + 6'd1;
        if (cnt_q == 6'd48) st_d = StDone;
      end
      StDone: st_d = StIdle;
      default: st_d = StIdle;
    endcase
  end

  assign done_o = (st_q == StDone);
  assign act_o = neg_q ? -quo_q[23:0] : quo_q[23:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) st_q <= StIdle;
    else st_q <= st_d;
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d; x_q <= x_d; x2_q <= x2_d; mag_q <= mag_d; den_q <= den_d;
    neg_q <= neg_d; cnt_q <= cnt_d; rem_q <= rem_d; quo_q <= quo_d;
  end
endmodule

// ===== hw/rtl/dcl2_merge.sv =====
`timescale 1ns / 1ps
// Combine both activations: head sums and the 1x1 mix, one product a cycle.
module dcl2_merge (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic signed [23:0] act0_i,
  input  logic signed [23:0] act1_i,
  input  dcl2_pkg::dcl2_in_t req_i,
  input  logic [63:0]        mix_i,
  input  logic [31:0]        obias_i,
  output logic               done_o,
  output dcl2_pkg::dcl2_out_t res_o
);
  import dcl2_pkg::*;

  logic [2:0] ph_q;
  logic busy_q;
  logic signed [47:0] v_q [2];
  logic signed [23:0] am;
  logic signed [15:0] wm;
  logic o_sel;
  logic signed [47:0] p;

  // phases 0..3: products [i][o] with i = ph[1], o = ph[0]
  assign o_sel = ph_q[0];
  assign am = ph_q[1] ? act1_i : act0_i;
  assign wm = 16'(mix_i >> (16 * ph_q[1:0]));
  assign p = 48'(am * wm);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0; ph_q <= '0; done_o <= 1'b0;
    end else begin
      done_o <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1; ph_q <= '0;
      end else if (busy_q) begin
        ph_q <= ph_q + 3'd1;
        if (ph_q == 3'd3) begin
          busy_q <= 1'b0; done_o <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      v_q[0] <= (48'(req_i.in_ch0) <<< 12) + (48'($signed(obias_i[15:0])) <<< 16);
      v_q[1] <= (48'(req_i.in_ch1) <<< 12) + (48'($signed(obias_i[31:16])) <<< 16);
      res_o.head_out0 <= sat25(25'(req_i.head_in0) + 25'(act0_i));
      res_o.head_out1 <= sat25(25'(req_i.head_in1) + 25'(act1_i));
    end else if (busy_q) begin
      v_q[o_sel] <= v_q[o_sel] + p;
    end
    if (busy_q && ph_q == 3'd3) begin
      res_o.out_ch0 <= rnd_sat(v_q[0]);
      res_o.out_ch1 <= rnd_sat(v_q[1] + p);
    end
  end
endmodule

// ===== hw/rtl/dilated_conv_layer_2ch_top.sv =====
`timescale 1ns / 1ps
// Per request, in order: 2 store reads, 7 tap/cond multiply-accumulate steps, tanh setup,
// 49 divide steps, lane done, then the mix. Only one request is in flight at a time;
// the bit-serial tanh divider takes most of the time spent on each request.
// A result held under out_stall_i blocks the next request until it is taken.
// Reset (rst_ni low, async): registers zero, dilation 1, pointer zero; a clear
// pass then zeroes all 2*MaxDilation+1 delay store entries before requests.
module dilated_conv_layer_2ch_top #(
  parameter int MaxDilation = 512
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  dcl2_pkg::dcl2_in_t   in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output dcl2_pkg::dcl2_out_t  out_data_o,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [2:0]           cfg_index_i,
  input  logic [63:0]          cfg_data_i
);
  import dcl2_pkg::*;

  localparam int Depth = 2 * MaxDilation + 1;
  localparam int Aw = $clog2(Depth);
  localparam int Dw = $clog2(MaxDilation + 1);

  localparam logic [2:0] StClr  = 3'd0;
  localparam logic [2:0] StIdle = 3'd1;
  localparam logic [2:0] StRd1  = 3'd2;
  localparam logic [2:0] StRd2  = 3'd3;
  localparam logic [2:0] StAcc  = 3'd4;
  localparam logic [2:0] StWait = 3'd5;
  localparam logic [2:0] StMix  = 3'd6;

  logic [2:0] st_q;
  logic [63:0] tap0_q, tap1_q, tap2_q, mix_q, bias_q;
  logic [31:0] obias_q;
  logic [9:0] dil_q;
  logic [Aw-1:0] wp_q, clr_q, p2_q;
  dcl2_in_t req_q;
  logic [47:0] s1_q, s2_q;
  logic [2:0] k_q;
  logic [Dw-1:0] d_eff;
  logic [Aw:0] ss, p1w, p2w;
  logic [Aw-1:0] p;
  logic ram_we;
  logic [Aw-1:0] ram_wa, ram_ra;
  logic [47:0] ram_wd, ram_rd;
  logic signed [23:0] a_sel [2];
  logic signed [15:0] w_sel [2];
  logic lane_done [2];
  logic lanes_done;
  logic signed [23:0] act [2];
  logic lane_start, lane_step, mix_done;
  dcl2_out_t mix_res;

  always_comb begin
    if (dil_q == '0) d_eff = Dw'(1);
    else if ({22'd0, dil_q} > 32'(MaxDilation)) d_eff = Dw'(MaxDilation);
    else d_eff = Dw'(dil_q);
    ss = (Aw + 1)'(2 * d_eff + 1);
    p = ({1'b0, wp_q} >= ss) ? '0 : wp_q;
    p1w = {1'b0, p} + ss - (Aw + 1)'(d_eff);
    if (p1w >= ss) p1w = p1w - ss;
    p2w = {1'b0, p} + ss - (Aw + 1)'(2 * d_eff);
    if (p2w >= ss) p2w = p2w - ss;
  end

  assign cfg_ready_o = 1'b1;
  assign in_stall_o = (st_q != StIdle) || (out_valid_o && out_stall_i);

  assign ram_we = (st_q == StClr) || (st_q == StIdle && in_valid_i && !in_stall_o);
  assign ram_wa = (st_q == StClr) ? clr_q : p;
  assign ram_wd = (st_q == StClr) ? 48'd0 : {in_data_i.in_ch1, in_data_i.in_ch0};
  assign ram_ra = (st_q == StIdle) ? Aw'(p1w) : p2_q;

  dcl2_ram #(.Width(48), .Depth(Depth)) u_store (
    .clk_i, .we_i(ram_we), .waddr_i(ram_wa), .wdata_i(ram_wd),
    .raddr_i(ram_ra), .rdata_o(ram_rd)
  );

  // step k: cur0, cur1, s1_0, s1_1, s2_0, s2_1, cond
  always_comb begin
    for (int o = 0; o < 2; o++) begin
      unique case (k_q)
        3'd0: begin a_sel[o] = req_q.in_ch0; w_sel[o] = 16'(tap0_q >> (16 * o)); end
        3'd1: begin a_sel[o] = req_q.in_ch1; w_sel[o] = 16'(tap0_q >> (16 * (2 + o))); end
        3'd2: begin a_sel[o] = s1_q[23:0]; w_sel[o] = 16'(tap1_q >> (16 * o)); end
        3'd3: begin a_sel[o] = s1_q[47:24]; w_sel[o] = 16'(tap1_q >> (16 * (2 + o))); end
        3'd4: begin a_sel[o] = s2_q[23:0]; w_sel[o] = 16'(tap2_q >> (16 * o)); end
        3'd5: begin a_sel[o] = s2_q[47:24]; w_sel[o] = 16'(tap2_q >> (16 * (2 + o))); end
        default: begin
          a_sel[o] = req_q.cond_sample; w_sel[o] = 16'(bias_q >> (16 * (2 + o)));
        end
      endcase
    end
  end

  assign lane_start = (st_q == StRd2);
  assign lane_step = (st_q == StAcc);
  assign lanes_done = lane_done[0] && lane_done[1];

  for (genvar o = 0; o < 2; o++) begin : g_lane
    dcl2_lane u_lane (
      .clk_i, .rst_ni, .start_i(lane_start), .step_i(lane_step),
      .a_i(a_sel[o]), .w_i(w_sel[o]), .bias_i(16'(bias_q >> (16 * o))),
      .done_o(lane_done[o]), .act_o(act[o])
    );
  end

  dcl2_merge u_merge (
    .clk_i, .rst_ni, .start_i(st_q == StWait && lanes_done),
    .act0_i(act[0]), .act1_i(act[1]), .req_i(req_q), .mix_i(mix_q),
    .obias_i(obias_q), .done_o(mix_done), .res_o(mix_res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= StClr; clr_q <= '0; wp_q <= '0; k_q <= '0; out_valid_o <= 1'b0;
      tap0_q <= '0; tap1_q <= '0; tap2_q <= '0; mix_q <= '0; bias_q <= '0;
      obias_q <= '0; dil_q <= 10'd1;
    end else begin
      if (out_valid_o && !out_stall_i) out_valid_o <= 1'b0;
      if (cfg_valid_i) begin
        unique case (cfg_index_i)
          RegTap0: tap0_q <= cfg_data_i;
          RegTap1: tap1_q <= cfg_data_i;
          RegTap2: tap2_q <= cfg_data_i;
          RegMix: mix_q <= cfg_data_i;
          RegBias: bias_q <= cfg_data_i;
          RegObias: obias_q <= cfg_data_i[31:0];
          RegDil: begin dil_q <= cfg_data_i[9:0]; wp_q <= '0; end
          default: ;
        endcase
      end
      unique case (st_q)
        StClr: begin
          clr_q <= clr_q + Aw'(1);
          if (clr_q == Aw'(Depth - 1)) st_q <= StIdle;
        end
        StIdle: if (in_valid_i && !in_stall_o) begin
          p2_q <= Aw'(p2w);
          wp_q <= ({1'b0, p} + 1'b1 == ss) ? '0 : p + Aw'(1);
          st_q <= StRd1;
        end
        StRd1: st_q <= StRd2;
        StRd2: begin st_q <= StAcc; k_q <= '0; end
        StAcc: begin
          k_q <= k_q + 3'd1;
          if (k_q == 3'd6) st_q <= StWait;
        end
        StWait: if (lanes_done) st_q <= StMix;
        StMix: if (mix_done) begin
          out_valid_o <= 1'b1; st_q <= StIdle;
        end
        default: st_q <= StIdle;
      endcase
    end
  end

  // lane step is high for k 0..6; the lane leaves accumulation the cycle after
  always_ff @(posedge clk_i) begin
    if (st_q == StIdle && in_valid_i && !in_stall_o) req_q <= in_data_i;
    if (st_q == StRd1) s1_q <= ram_rd;
    if (st_q == StRd2) s2_q <= ram_rd;
    if (mix_done) out_data_o <= mix_res;
  end
endmodule

// ===== hw/rtl/dcl2_checker.sv =====
`timescale 1ns / 1ps
module dcl2_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid_i,
  input logic in_stall_o,
  input logic out_valid_o,
  input logic out_stall_i,
  input dcl2_pkg::dcl2_out_t out_data_o
);
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("result dropped under stall");
  a_busy_after_req: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("request taken while busy");
  a_no_quick_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> !$rose(out_valid_o))
    else $error("result too early");
endmodule

bind dilated_conv_layer_2ch_top dcl2_checker u_chk (
  .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .out_valid_o, .out_stall_i, .out_data_o
);
